[rtl/core/sos_pkg.sv]
// Types and constants shared by the supply output supervisor.
package sos_pkg;

  localparam int unsigned CodeW     = 13;
  localparam int unsigned LimitW    = 23;
  localparam int unsigned TempW     = 12;
  localparam int unsigned PrescaleW = 8;
  localparam int unsigned MsW       = 16;
  localparam int unsigned CurrentW  = 16;
  localparam int unsigned PowerW    = 18;
  localparam int unsigned OnTimeW   = 32;
  localparam int unsigned AccW      = 48;
  localparam int unsigned CfgDataW  = 23;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned LimitMsW  = 33;

  localparam logic [LimitMsW-1:0] MsPerSecond = 33'd1000;

  localparam logic [CodeW-1:0]     PresetVoltageRst = 13'd2500;
  localparam logic [CodeW-1:0]     PresetCurrentRst = 13'd5000;
  localparam logic [TempW-1:0]     OverheatRst      = 12'd800;
  localparam logic [PrescaleW-1:0] PrescaleRst      = 8'd10;

  typedef enum logic [0:0] {
    OP_RAMP    = 1'b0,
    OP_CONTROL = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_STANDBY  = 3'd0,
    ST_CC       = 3'd1,
    ST_CV       = 3'd2,
    ST_PAUSED   = 3'd3,
    ST_OVERHEAT = 3'd4,
    ST_TIMER    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    BEEP_NONE     = 3'd0,
    BEEP_MODE     = 3'd1,
    BEEP_TOGGLE   = 3'd2,
    BEEP_ON_TIMER = 3'd3,
    BEEP_OVERHEAT = 3'd4,
    BEEP_TIMER    = 3'd5
  } beep_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRESET_VOLTAGE = 3'd0,
    CFG_PRESET_CURRENT = 3'd1,
    CFG_RUN_LIMIT      = 3'd2,
    CFG_OVERHEAT_LIMIT = 3'd3,
    CFG_RAMP_PRESCALE  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic               load_enable;
    status_e            indicator;
    logic [CodeW-1:0]   voltage_drive;
    logic [CodeW-1:0]   current_drive;
    logic [OnTimeW-1:0] run_time_ms;
    logic [AccW-1:0]    charge_acc;
    logic [AccW-1:0]    energy_acc;
    beep_e              beep_code;
  } result_t;

endpackage

[rtl/core/supply_output_supervisor.sv]
// Output supervisor of a bench supply: DAC ramp, load control, halts and accumulators.
// Pipeline: an accepted request is held in the input register, then its result is
// registered in the result register. Throughput: one request per cycle while the result
// channel is not stalled; the state update of one request is complete before the next
// request leaves the input register.
// Reset: asynchronous, active low; clears valid flags and supervisor state, loads register defaults.
module supply_output_supervisor
  import sos_pkg::*;
#(
  parameter int unsigned DAC_MAX = 5000
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  // Request channel.
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 op_i,
  input  logic                 button_click_i,
  input  logic                 cc_mode_i,
  input  logic signed [TempW-1:0] temperature_i,
  input  logic                 sample_due_i,
  input  logic [MsW-1:0]       elapsed_ms_i,
  input  logic [CurrentW-1:0]  current_ma_i,
  input  logic [PowerW-1:0]    power_mw_i,
  // Result channel.
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 load_enable_o,
  output logic [2:0]           indicator_o,
  output logic [CodeW-1:0]     voltage_drive_o,
  output logic [CodeW-1:0]     current_drive_o,
  output logic [OnTimeW-1:0]   run_time_ms_o,
  output logic [AccW-1:0]      charge_acc_o,
  output logic [AccW-1:0]      energy_acc_o,
  output logic [2:0]           beep_code_o
);

  // The ramp target saturates at the DAC full scale. DAC_MAX may exceed the
  // preset range, so the comparison is made on 16 bits.
  localparam logic [15:0] DacMax = 16'(DAC_MAX);

  // Configuration registers. The run limit is kept in milliseconds so that
  // the expiry test is a plain compare against the run time.
  logic [CodeW-1:0]        preset_v_q, preset_i_q;
  logic [LimitMsW-1:0]     limit_ms_q;
  logic signed [TempW-1:0] overheat_q;
  logic [PrescaleW-1:0]    prescale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_v_q <= PresetVoltageRst;
      preset_i_q <= PresetCurrentRst;
      limit_ms_q <= '0;
      overheat_q <= OverheatRst;
      prescale_q <= PrescaleRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRESET_VOLTAGE: preset_v_q <= cfg_wdata_i[CodeW-1:0];
        CFG_PRESET_CURRENT: preset_i_q <= cfg_wdata_i[CodeW-1:0];
        CFG_RUN_LIMIT:      limit_ms_q <= LimitMsW'(cfg_wdata_i[LimitW-1:0]) * MsPerSecond;
        CFG_OVERHEAT_LIMIT: overheat_q <= cfg_wdata_i[TempW-1:0];
        CFG_RAMP_PRESCALE:  prescale_q <= cfg_wdata_i[PrescaleW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control. The whole pipe moves when the result register is free
  // or being emptied; the input register refills in the same cycle.
  logic in_v_q, out_v_q, advance, in_fire, step_en;

  assign advance    = !out_v_q || out_ready_i;
  assign in_ready_o = !in_v_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;
  assign step_en    = in_v_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (advance) begin
        out_v_q <= in_v_q;
      end
    end
  end

  // Input register holds the accepted request.
  op_e                     op_q;
  logic                    click_q, cc_q, due_q;
  logic signed [TempW-1:0] temp_q;
  logic [MsW-1:0]          ems_q;
  logic [CurrentW-1:0]     ima_q;
  logic [PowerW-1:0]       pmw_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= op_e'(op_i);
      click_q <= button_click_i;
      cc_q    <= cc_mode_i;
      temp_q  <= temperature_i;
      due_q   <= sample_due_i;
      ems_q   <= elapsed_ms_i;
      ima_q   <= current_ma_i;
      pmw_q   <= power_mw_i;
    end
  end

  // Supervisor state.
  logic                 load_on_q, load_on_d;
  status_e              status_q, status_d;
  logic                 prev_cc_q, prev_cc_d;
  logic [OnTimeW-1:0]   on_time_q, on_time_d;
  logic [CodeW-1:0]     vcode_q, vcode_d, icode_q, icode_d;
  logic [PrescaleW-1:0] pcount_q, pcount_d;
  logic [AccW-1:0]      charge_q, charge_d, energy_q, energy_d;
  beep_e                beep_d;

  // Ramp step: one code toward the saturated preset.
  logic [CodeW-1:0]     target_v, target_i, vstep, istep;
  logic [PrescaleW-1:0] pcount_inc;

  assign target_v = ({3'b000, preset_v_q} > DacMax) ? DacMax[CodeW-1:0] : preset_v_q;
  assign target_i = ({3'b000, preset_i_q} > DacMax) ? DacMax[CodeW-1:0] : preset_i_q;
  assign vstep = (vcode_q < target_v) ? vcode_q + 1'b1 :
                 (vcode_q > target_v) ? vcode_q - 1'b1 : vcode_q;
  assign istep = (icode_q < target_i) ? icode_q + 1'b1 :
                 (icode_q > target_i) ? icode_q - 1'b1 : icode_q;
  assign pcount_inc = pcount_q + 1'b1;

  // Halt conditions use the run time from before this request.
  logic timer_on, hot, expired;

  assign timer_on = (limit_ms_q != '0);
  assign hot      = temp_q > overheat_q;
  assign expired  = timer_on && ({1'b0, on_time_q} >= limit_ms_q);

  // Integration: one product per accumulator, then a saturating add.
  logic [CurrentW+MsW-1:0] charge_prod;
  logic [PowerW+MsW-1:0]   energy_prod;
  logic [AccW:0]           charge_sum, energy_sum;

  assign charge_prod = ima_q * ems_q;
  assign energy_prod = pmw_q * ems_q;
  assign charge_sum  = {1'b0, charge_q} + (AccW+1)'(charge_prod);
  assign energy_sum  = {1'b0, energy_q} + (AccW+1)'(energy_prod);

  always_comb begin
    load_on_d = load_on_q;
    status_d  = status_q;
    prev_cc_d = prev_cc_q;
    on_time_d = on_time_q;
    vcode_d   = vcode_q;
    icode_d   = icode_q;
    pcount_d  = pcount_q;
    charge_d  = charge_q;
    energy_d  = energy_q;
    beep_d    = BEEP_NONE;

    if (op_q == OP_RAMP) begin
      pcount_d = pcount_inc;
      if (pcount_inc >= prescale_q) begin
        pcount_d = '0;
        vcode_d  = vstep;
        icode_d  = istep;
      end
    end else begin
      if ((cc_q != prev_cc_q) && load_on_q) begin
        beep_d = BEEP_MODE;
      end

      // A click toggles the load and restarts the ramp from zero.
      if (click_q) begin
        load_on_d = !load_on_q;
        beep_d    = (!load_on_q && timer_on) ? BEEP_ON_TIMER : BEEP_TOGGLE;
        vcode_d   = '0;
        icode_d   = '0;
        status_d  = ST_STANDBY;
      end

      // A halt indication is sticky until the next click.
      if (status_d != ST_OVERHEAT && status_d != ST_TIMER) begin
        if (on_time_q == '0 && !load_on_d) begin
          status_d = ST_STANDBY;
        end else if (load_on_d && cc_q) begin
          status_d = ST_CC;
        end else if (load_on_d) begin
          status_d = ST_CV;
        end else begin
          status_d = ST_PAUSED;
        end
      end

      // Overheat wins over timer expiry unless it is already being shown.
      if (hot || expired) begin
        load_on_d = 1'b0;
        vcode_d   = '0;
        icode_d   = '0;
        if (hot && status_d != ST_OVERHEAT) begin
          status_d = ST_OVERHEAT;
          beep_d   = BEEP_OVERHEAT;
        end else if (expired && status_d != ST_TIMER) begin
          status_d = ST_TIMER;
          beep_d   = BEEP_TIMER;
        end
      end

      if (due_q && load_on_d) begin
        charge_d  = charge_sum[AccW] ? '1 : charge_sum[AccW-1:0];
        energy_d  = energy_sum[AccW] ? '1 : energy_sum[AccW-1:0];
        on_time_d = on_time_q + OnTimeW'(ems_q);
      end

      prev_cc_d = cc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_on_q <= 1'b0;
      status_q  <= ST_STANDBY;
      prev_cc_q <= 1'b0;
      on_time_q <= '0;
      vcode_q   <= '0;
      icode_q   <= '0;
      pcount_q  <= '0;
      charge_q  <= '0;
      energy_q  <= '0;
    end else if (step_en) begin
      load_on_q <= load_on_d;
      status_q  <= status_d;
      prev_cc_q <= prev_cc_d;
      on_time_q <= on_time_d;
      vcode_q   <= vcode_d;
      icode_q   <= icode_d;
      pcount_q  <= pcount_d;
      charge_q  <= charge_d;
      energy_q  <= energy_d;
    end
  end

  // Result register: the state after the request, drives forced to zero
  // while the load is off.
  result_t res_d, res_q;

  always_comb begin
    res_d.load_enable   = load_on_d;
    res_d.indicator     = status_d;
    res_d.voltage_drive = load_on_d ? vcode_d : '0;
    res_d.current_drive = load_on_d ? icode_d : '0;
    res_d.run_time_ms   = on_time_d;
    res_d.charge_acc    = charge_d;
    res_d.energy_acc    = energy_d;
    res_d.beep_code     = beep_d;
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_v_q;
  assign load_enable_o   = res_q.load_enable;
  assign indicator_o     = res_q.indicator;
  assign voltage_drive_o = res_q.voltage_drive;
  assign current_drive_o = res_q.current_drive;
  assign run_time_ms_o   = res_q.run_time_ms;
  assign charge_acc_o    = res_q.charge_acc;
  assign energy_acc_o    = res_q.energy_acc;
  assign beep_code_o     = res_q.beep_code;

  // Drives are zero whenever a result reports the load as off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !load_enable_o) |-> (voltage_drive_o == '0 && current_drive_o == '0))
    else $error("drive non-zero with load off");

  // A halt indication always comes with the load switched off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (indicator_o == ST_OVERHEAT || indicator_o == ST_TIMER))
      |-> !load_enable_o)
    else $error("load on during halt");

  // State only moves when a request is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en |=> ($stable(on_time_q) && $stable(charge_q) && $stable(pcount_q)))
    else $error("state changed without a request");

  // The saturating accumulators never decrease.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |=> (charge_q >= $past(charge_q) && energy_q >= $past(energy_q)))
    else $error("accumulator decreased");

endmodule

[sim/tb_supply_output_supervisor.sv]
// Self-checking testbench for the supply output supervisor: directed table, then randomised requests.
module tb_supply_output_supervisor;
  import sos_pkg::*;

  // The block is built with its usual full scale, so the ramp ceiling is 5000 codes.
  localparam int unsigned DacMax        = 5000;
  localparam int          ClkHalf       = 6;
  localparam int          ResetCycles   = 11;
  // Longest correct quiet stretch is one sender gap plus one receiver stall plus the
  // pass through the input and result registers, or a run of register writes; the
  // watchdog allows far more.
  localparam int          QuietLimit    = 400;
  // Ramp ticks at a prescale of zero, each of which moves both codes one step.
  localparam int          SweepTicks    = 150;
  localparam int          RandomPhases  = 14;
  localparam int          PhaseRequests = 106;

  // One request as the testbench sees it, one field per input port.
  typedef struct {
    op_e                     op;
    logic                    click;
    logic                    cc;
    logic signed [TempW-1:0] temp;
    logic                    due;
    logic [MsW-1:0]          ems;
    logic [CurrentW-1:0]     ima;
    logic [PowerW-1:0]       pmw;
  } request_t;

  // A row of the directed table; where typed is set, want holds the result read off by hand.
  typedef struct {
    request_t req;
    bit       typed;
    result_t  want;
  } stimulus_row_t;

  // Everything off and cleared, as straight after reset.
  localparam result_t StandbyResult = '{
    load_enable: 1'b0, indicator: ST_STANDBY, voltage_drive: '0, current_drive: '0,
    run_time_ms: '0, charge_acc: '0, energy_acc: '0, beep_code: BEEP_NONE};

  // First switch-on in CC mode with every integrator input at full scale.
  localparam result_t FirstOnResult = '{
    load_enable: 1'b1, indicator: ST_CC, voltage_drive: '0, current_drive: '0,
    run_time_ms: 32'd65535, charge_acc: 48'd4294836225, energy_acc: 48'd17179541505,
    beep_code: BEEP_TOGGLE};

  // Hottest reading trips the output; the totals keep what the first pass added.
  localparam result_t OverheatResult = '{
    load_enable: 1'b0, indicator: ST_OVERHEAT, voltage_drive: '0, current_drive: '0,
    run_time_ms: 32'd65535, charge_acc: 48'd4294836225, energy_acc: 48'd17179541505,
    beep_code: BEEP_OVERHEAT};

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxW-1:0]      cfg_idx_i;
  logic [CfgDataW-1:0]     cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    op_i;
  logic                    button_click_i;
  logic                    cc_mode_i;
  logic signed [TempW-1:0] temperature_i;
  logic                    sample_due_i;
  logic [MsW-1:0]          elapsed_ms_i;
  logic [CurrentW-1:0]     current_ma_i;
  logic [PowerW-1:0]       power_mw_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    load_enable_o;
  logic [2:0]              indicator_o;
  logic [CodeW-1:0]        voltage_drive_o;
  logic [CodeW-1:0]        current_drive_o;
  logic [OnTimeW-1:0]      run_time_ms_o;
  logic [AccW-1:0]         charge_acc_o;
  logic [AccW-1:0]         energy_acc_o;
  logic [2:0]              beep_code_o;

  supply_output_supervisor #(
    .DAC_MAX(DacMax)
  ) DUT (.*);

  // Settings as the block should hold them; they start at the reset defaults.
  logic [CodeW-1:0]        set_preset_v  = PresetVoltageRst;
  logic [CodeW-1:0]        set_preset_i  = PresetCurrentRst;
  logic [LimitW-1:0]       set_run_limit = '0;
  logic signed [TempW-1:0] set_overheat  = OverheatRst;
  logic [PrescaleW-1:0]    set_prescale  = PrescaleRst;

  // Supervisor state as predicted from the requests accepted so far.
  logic                    sup_load_on    = 1'b0;
  status_e                 sup_status     = ST_STANDBY;
  logic                    sup_last_cc    = 1'b0;
  logic [OnTimeW-1:0]      sup_on_time    = '0;
  logic [CodeW-1:0]        sup_v_code     = '0;
  logic [CodeW-1:0]        sup_i_code     = '0;
  logic [PrescaleW-1:0]    sup_ramp_count = '0;
  logic [AccW-1:0]         sup_charge     = '0;
  logic [AccW-1:0]         sup_energy     = '0;

  result_t       predicted_outputs[$];
  stimulus_row_t directed_rows[$];
  result_t       oldest_expected;
  bit            gaps_on = 1'b1;
  int            mismatch_count = 0;
  int            quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  // One DAC step toward the preset, which is capped at full scale first.
  function automatic logic [CodeW-1:0] step_code(logic [CodeW-1:0] code,
                                                 logic [CodeW-1:0] preset);
    logic [CodeW-1:0] target;
    target = (preset > CodeW'(DacMax)) ? CodeW'(DacMax) : preset;
    if (code < target) return code + 1'b1;
    if (code > target) return code - 1'b1;
    return code;
  endfunction

  function automatic logic [AccW-1:0] add_saturating(logic [AccW-1:0] acc,
                                                     logic [AccW-1:0] inc);
    logic [AccW:0] sum;
    sum = {1'b0, acc} + {1'b0, inc};
    return sum[AccW] ? '1 : sum[AccW-1:0];
  endfunction

  // Applies one accepted request to the predicted state and returns what the block
  // should report for it.
  task automatic supervise_request(input request_t r, output result_t res);
    beep_e beep;
    logic  hot;
    logic  expired;
    beep = BEEP_NONE;
    if (r.op == OP_RAMP) begin
      // A ramp tick only moves the prescaler and, when it comes round, both codes.
      sup_ramp_count = sup_ramp_count + 1'b1;
      if (sup_ramp_count >= set_prescale) begin
        sup_ramp_count = '0;
        sup_v_code     = step_code(sup_v_code, set_preset_v);
        sup_i_code     = step_code(sup_i_code, set_preset_i);
      end
    end else begin
      if (r.cc != sup_last_cc && sup_load_on) beep = BEEP_MODE;
      if (r.click) begin
        sup_load_on = !sup_load_on;
        beep        = (sup_load_on && set_run_limit != '0) ? BEEP_ON_TIMER : BEEP_TOGGLE;
        sup_v_code  = '0;
        sup_i_code  = '0;
        sup_status  = ST_STANDBY;
      end
      // A halt indication sticks until the next click clears it.
      if (sup_status != ST_OVERHEAT && sup_status != ST_TIMER) begin
        if (sup_on_time == '0 && !sup_load_on) sup_status = ST_STANDBY;
        else if (sup_load_on && r.cc)          sup_status = ST_CC;
        else if (sup_load_on)                  sup_status = ST_CV;
        else                                   sup_status = ST_PAUSED;
      end
      hot     = r.temp > set_overheat;
      expired = set_run_limit != '0 &&
                (sup_on_time / 32'd1000) >= OnTimeW'(set_run_limit);
      if (hot || expired) begin
        // The codes are cleared even if the load was already off.
        sup_load_on = 1'b0;
        sup_v_code  = '0;
        sup_i_code  = '0;
        if (hot && sup_status != ST_OVERHEAT) begin
          sup_status = ST_OVERHEAT;
          beep       = BEEP_OVERHEAT;
        end else if (expired && sup_status != ST_TIMER) begin
          sup_status = ST_TIMER;
          beep       = BEEP_TIMER;
        end
      end
      if (r.due && sup_load_on) begin
        sup_charge  = add_saturating(sup_charge, AccW'(r.ima) * AccW'(r.ems));
        sup_energy  = add_saturating(sup_energy, AccW'(r.pmw) * AccW'(r.ems));
        sup_on_time = sup_on_time + OnTimeW'(r.ems);
      end
      sup_last_cc = r.cc;
    end
    res.load_enable   = sup_load_on;
    res.indicator     = sup_status;
    res.voltage_drive = sup_load_on ? sup_v_code : '0;
    res.current_drive = sup_load_on ? sup_i_code : '0;
    res.run_time_ms   = sup_on_time;
    res.charge_acc    = sup_charge;
    res.energy_acc    = sup_energy;
    res.beep_code     = beep;
  endtask

  function automatic request_t make_request(op_e op, bit click, bit cc, int temp, bit due,
                                            int ems, int ima, int pmw);
    request_t r;
    r.op    = op;
    r.click = click;
    r.cc    = cc;
    r.temp  = TempW'(temp);
    r.due   = due;
    r.ems   = MsW'(ems);
    r.ima   = CurrentW'(ima);
    r.pmw   = PowerW'(pmw);
    return r;
  endfunction

  // Mostly sensible operation: clicks bring the load back when it is off and are rare
  // while it runs, the mode seldom flips and the temperature mostly stays below the
  // limit. One pass in ten carries a wholly random reading to trip the halts.
  function automatic request_t random_request();
    request_t r;
    int       lim;
    lim     = set_overheat;
    r.op    = ($urandom_range(0, 99) < 35) ? OP_RAMP : OP_CONTROL;
    r.click = $urandom_range(0, 99) < (sup_load_on ? 4 : 40);
    r.cc    = ($urandom_range(0, 9) == 0) ? !sup_last_cc : sup_last_cc;
    if ($urandom_range(0, 9) == 0) r.temp = TempW'($urandom);
    else                           r.temp = TempW'(int'($urandom_range(0, lim + 2048)) - 2048);
    r.due   = $urandom_range(0, 9) < 7;
    r.ems   = ($urandom_range(0, 9) < 6) ? MsW'($urandom_range(0, 2000)) : MsW'($urandom);
    r.ima   = CurrentW'($urandom);
    r.pmw   = PowerW'($urandom);
    return r;
  endfunction

  task automatic add_row(input request_t r, input bit typed = 1'b0,
                         input result_t want = StandbyResult);
    stimulus_row_t row;
    row.req   = r;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  // Valid is only lowered when a gap is drawn, so back-to-back requests keep it high.
  task automatic send_request(input request_t r, input bit typed, input result_t want);
    int      gap;
    result_t predicted;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i           <= r.op;
    button_click_i <= r.click;
    cc_mode_i      <= r.cc;
    temperature_i  <= r.temp;
    sample_due_i   <= r.due;
    elapsed_ms_i   <= r.ems;
    current_ma_i   <= r.ima;
    power_mw_i     <= r.pmw;
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    supervise_request(r, predicted);
    predicted_outputs.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // Stops requesting and waits until every outstanding result has been taken.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Writes one register and mirrors it in the predicted settings; called at a falling edge.
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_PRESET_VOLTAGE: set_preset_v  = data[CodeW-1:0];
      CFG_PRESET_CURRENT: set_preset_i  = data[CodeW-1:0];
      CFG_RUN_LIMIT:      set_run_limit = data[LimitW-1:0];
      CFG_OVERHEAT_LIMIT: set_overheat  = data[TempW-1:0];
      CFG_RAMP_PRESCALE:  set_prescale  = data[PrescaleW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Presets span zero, full scale, the top of the field (above full scale), noise across
  // the whole data word, and a low target.
  function automatic logic [CfgDataW-1:0] preset_choice(int option);
    case (option)
      0:       return '0;
      1:       return CfgDataW'(DacMax);
      2:       return '1;
      3:       return CfgDataW'($urandom);
      default: return CfgDataW'($urandom_range(0, 300));
    endcase
  endfunction

  // Each register walks through its options in turn, so the extremes all come round.
  task automatic configure_phase(input int phase);
    logic [CfgDataW-1:0] pick;
    cfg_write(CFG_PRESET_VOLTAGE, preset_choice(phase % 5));
    cfg_write(CFG_PRESET_CURRENT, preset_choice((phase + 2) % 5));
    case ((phase + 1) % 5)
      0:       pick = '0;
      1:       pick = CfgDataW'(1);
      2:       pick = CfgDataW'(255);
      3:       pick = CfgDataW'($urandom_range(1, 4));
      default: pick = CfgDataW'($urandom);
    endcase
    cfg_write(CFG_RAMP_PRESCALE, pick);
    case ((phase + 3) % 5)
      0:       pick = CfgDataW'(12'h7FF);
      1:       pick = CfgDataW'(12'h800);
      2:       pick = CfgDataW'($urandom);
      default: pick = CfgDataW'(int'($urandom_range(0, 2400)) - 400);
    endcase
    cfg_write(CFG_OVERHEAT_LIMIT, pick);
    // A limit just above the time run so far makes the timer expire within the phase.
    case ((phase + 4) % 5)
      0, 1:    pick = '0;
      2:       pick = CfgDataW'(sup_on_time / 1000 + $urandom_range(1, 20));
      3:       pick = '1;
      default: pick = CfgDataW'($urandom);
    endcase
    cfg_write(CFG_RUN_LIMIT, pick);
    // Writes to the unused indices must leave every setting alone.
    for (int idx = CFG_RAMP_PRESCALE + 1; idx < (1 << CfgIdxW); idx++) begin
      cfg_write(CfgIdxW'(idx), CfgDataW'($urandom));
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Result sink: before each result it holds ready low for a drawn number of cycles.
  initial begin : result_sink
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = gaps_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Every accepted result is matched field by field against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_outputs.size() == 0) begin
        report_mismatch("result with nothing outstanding", '0, '0);
      end else begin
        oldest_expected = predicted_outputs.pop_front();
        if (load_enable_o !== oldest_expected.load_enable)
          report_mismatch("load_enable", load_enable_o, oldest_expected.load_enable);
        if (indicator_o !== oldest_expected.indicator)
          report_mismatch("indicator", indicator_o, oldest_expected.indicator);
        if (voltage_drive_o !== oldest_expected.voltage_drive)
          report_mismatch("voltage_drive", voltage_drive_o, oldest_expected.voltage_drive);
        if (current_drive_o !== oldest_expected.current_drive)
          report_mismatch("current_drive", current_drive_o, oldest_expected.current_drive);
        if (run_time_ms_o !== oldest_expected.run_time_ms)
          report_mismatch("run_time_ms", run_time_ms_o, oldest_expected.run_time_ms);
        if (charge_acc_o !== oldest_expected.charge_acc)
          report_mismatch("charge_acc", charge_acc_o, oldest_expected.charge_acc);
        if (energy_acc_o !== oldest_expected.energy_acc)
          report_mismatch("energy_acc", energy_acc_o, oldest_expected.energy_acc);
        if (beep_code_o !== oldest_expected.beep_code)
          report_mismatch("beep_code", beep_code_o, oldest_expected.beep_code);
      end
    end
  end

  // Watchdog: too long without a handshake on either side means the block has hung.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else                                                          quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_supply_output_supervisor: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    op_i           = OP_RAMP;
    button_click_i = 1'b0;
    cc_mode_i      = 1'b0;
    temperature_i  = '0;
    sample_due_i   = 1'b0;
    elapsed_ms_i   = '0;
    current_ma_i   = '0;
    power_mw_i     = '0;

    // Directed table, run with the reset settings. A ramp tick and an idle pass leave
    // everything at zero; the first switch-on integrates full-scale readings.
    add_row(make_request(OP_RAMP, 0, 0, 0, 0, 0, 0, 0), 1'b1, StandbyResult);
    add_row(make_request(OP_CONTROL, 0, 0, -2048, 1, 65535, 65535, 262143), 1'b1,
            StandbyResult);
    add_row(make_request(OP_CONTROL, 1, 1, 800, 1, 65535, 65535, 262143), 1'b1,
            FirstOnResult);
    // Mode flips to CV while the load is on, which beeps.
    add_row(make_request(OP_CONTROL, 0, 0, 0, 0, 0, 0, 0));
    // Nine ramp ticks bring the prescaler round for one step; their other fields carry
    // noise that must be ignored, a click among it.
    for (int n = 0; n < 9; n++) begin
      add_row(make_request(OP_RAMP, 1, 1, 2047, 1, 65535, 65535, 262143));
    end
    // Overheat trips the output, then holds without a second beep, codes cleared
    // although the load is already off.
    add_row(make_request(OP_CONTROL, 0, 0, 2047, 1, 100, 500, 700), 1'b1, OverheatResult);
    add_row(make_request(OP_CONTROL, 0, 0, 2047, 1, 100, 500, 700));
    // Back on, a tiny integration, then off again into the paused state.
    add_row(make_request(OP_CONTROL, 1, 1, 0, 1, 1, 1, 1));
    add_row(make_request(OP_CONTROL, 1, 1, 0, 0, 0, 0, 0));
    add_row(make_request(OP_CONTROL, 0, 0, 0, 1, 10, 10, 10));
    // A click in a pass that also overheats: the halt beep is the one reported.
    add_row(make_request(OP_CONTROL, 1, 0, 801, 0, 0, 0, 0));
    // On with zero elapsed time, then a click together with a mode change.
    add_row(make_request(OP_CONTROL, 1, 0, 0, 1, 0, 65535, 262143));
    add_row(make_request(OP_CONTROL, 1, 1, 0, 0, 0, 0, 0));

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[n]) begin
      send_request(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].want);
    end

    // Fast sweep: prescale zero steps on every tick and the voltage preset sits above
    // full scale, so both codes climb by one on every tick.
    wait_idle();
    cfg_write(CFG_RAMP_PRESCALE, '0);
    cfg_write(CFG_PRESET_VOLTAGE, '1);
    cfg_write(CFG_PRESET_CURRENT, CfgDataW'(DacMax));
    cfg_write(CFG_RUN_LIMIT, '0);
    cfg_write(CFG_OVERHEAT_LIMIT, CfgDataW'(12'h7FF));
    cfg_we_i <= 1'b0;
    gaps_on = 1'b0;
    send_request(make_request(OP_CONTROL, 1, 0, 0, 0, 0, 0, 0), 1'b0, StandbyResult);
    repeat (SweepTicks) begin
      request_t tick;
      tick    = random_request();
      tick.op = OP_RAMP;
      send_request(tick, 1'b0, StandbyResult);
    end

    // Randomised phases, each with fresh settings; every fourth runs without idling.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      wait_idle();
      configure_phase(phase);
      gaps_on = (phase % 4) != 3;
      repeat (PhaseRequests) send_request(random_request(), 1'b0, StandbyResult);
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && predicted_outputs.size() == 0) begin
      $display("tb_supply_output_supervisor: done, clean");
    end else begin
      $display("tb_supply_output_supervisor: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/sos_pkg.sv
rtl/core/supply_output_supervisor.sv
sim/tb_supply_output_supervisor.sv
